// File: rtl/rtc_pkg.sv
package rtc_pkg;

  // item codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // tick rate codes
  localparam logic [1:0] RATE_1HZ   = 2'd0;
  localparam logic [1:0] RATE_10HZ  = 2'd1;
  localparam logic [1:0] RATE_100HZ = 2'd2;
  localparam logic [1:0] RATE_1KHZ  = 2'd3;

  localparam logic [6:0]  STEP_10HZ    = 7'd100;
  localparam logic [6:0]  STEP_100HZ   = 7'd10;
  localparam logic [6:0]  STEP_1KHZ    = 7'd1;
  localparam logic [10:0] MS_PER_SEC   = 11'd1000;
  localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
  localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
  localparam logic [5:0]  HOUR_PER_DAY = 6'd24;
  localparam logic [4:0]  MONTH_PER_YR = 5'd12;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [11:0] YEAR_BASE    = 12'd1900;
  localparam logic [11:0] YEAR_OFFSET  = 12'd2000;

  localparam logic [11:0] YEAR_RST  = 12'd2000;
  localparam logic [31:0] EPOCH_RST = 32'd946684800;

  typedef struct packed {
    logic        mode;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [31:0] set_epoch;
  } rtc_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millis;
    logic [31:0] uptime;
    logic [31:0] epoch;
  } rtc_state_t;

  // days per month, february without leap day, invalid months have none
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/rtc_core.sv
module rtc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  rtc_pkg::rtc_item_t item,
  input  logic [1:0]         rate_sel,
  output rtc_pkg::rtc_state_t st_nxt
);

  rtc_pkg::rtc_state_t st_r;

  logic [6:0]  step;
  logic [10:0] ms_sum;
  logic        sec_done;
  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [5:0]  day_lim;
  logic [4:0]  month_inc;

  always_comb begin
    case (rate_sel)
      rtc_pkg::RATE_10HZ:  step = rtc_pkg::STEP_10HZ;
      rtc_pkg::RATE_100HZ: step = rtc_pkg::STEP_100HZ;
      default:             step = rtc_pkg::STEP_1KHZ;
    endcase
  end

  assign ms_sum    = {1'b0, st_r.millis} + {4'd0, step};
  assign sec_inc   = {1'b0, st_r.second} + 7'd1;
  assign min_inc   = {1'b0, st_r.minute} + 7'd1;
  assign hour_inc  = {1'b0, st_r.hour} + 6'd1;
  assign day_inc   = {1'b0, st_r.day} + 6'd1;
  assign month_inc = {1'b0, st_r.month} + 5'd1;
  // leap day when the year is divisible by 4
  assign day_lim   = {1'b0, rtc_pkg::month_len(st_r.month)}
                   + {5'd0, (st_r.month == rtc_pkg::MONTH_FEB) && (st_r.year[1:0] == 2'b00)};

  always_comb begin
    st_nxt   = st_r;
    sec_done = 1'b0;
    if (item.mode == rtc_pkg::MODE_LOAD) begin
      st_nxt.year   = (item.set_year < rtc_pkg::YEAR_BASE) ?
                      item.set_year + rtc_pkg::YEAR_OFFSET : item.set_year;
      st_nxt.month  = item.set_month;
      st_nxt.day    = item.set_day;
      st_nxt.hour   = item.set_hour;
      st_nxt.minute = item.set_minute;
      st_nxt.second = item.set_second;
      st_nxt.epoch  = item.set_epoch;
    end else begin
      if (rate_sel == rtc_pkg::RATE_1HZ) begin
        sec_done = 1'b1;
      end else if (ms_sum >= rtc_pkg::MS_PER_SEC) begin
        st_nxt.millis = 10'd0;
        sec_done      = 1'b1;
      end else begin
        st_nxt.millis = ms_sum[9:0];
      end
      if (sec_done) begin
        st_nxt.uptime = st_r.uptime + 32'd1;
        st_nxt.epoch  = st_r.epoch + 32'd1;
        // carry ripple, each stage only when the one below wrapped
        if (sec_inc < rtc_pkg::SEC_PER_MIN) begin
          st_nxt.second = sec_inc[5:0];
        end else begin
          st_nxt.second = 6'd0;
          if (min_inc < rtc_pkg::MIN_PER_HOUR) begin
            st_nxt.minute = min_inc[5:0];
          end else begin
            st_nxt.minute = 6'd0;
            if (hour_inc < rtc_pkg::HOUR_PER_DAY) begin
              st_nxt.hour = hour_inc[4:0];
            end else begin
              st_nxt.hour = 5'd0;
              if (day_inc <= day_lim) begin
                st_nxt.day = day_inc[4:0];
              end else begin
                st_nxt.day = 5'd1;
                if (month_inc <= rtc_pkg::MONTH_PER_YR) begin
                  st_nxt.month = month_inc[3:0];
                end else begin
                  st_nxt.month = 4'd1;
                  st_nxt.year  = st_r.year + 12'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.year   <= rtc_pkg::YEAR_RST;
      st_r.month  <= 4'd1;
      st_r.day    <= 5'd1;
      st_r.hour   <= 5'd0;
      st_r.minute <= 6'd0;
      st_r.second <= 6'd0;
      st_r.millis <= 10'd0;
      st_r.uptime <= 32'd0;
      st_r.epoch  <= rtc_pkg::EPOCH_RST;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_uptime_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(st_r.uptime))
    else $error("uptime moved with no item in process");
`endif

endmodule

// File: rtl/rtc_calendar_tick.sv
// channel  direction  handshake               payload
// in       input      in_valid / in_stall     in_mode, in_set_year .. in_set_epoch
// out      output     out_valid / out_stall   out_year .. out_epoch
// cfg      input      cfg_wr_en               cfg_wr_data (tick_rate_sel)
//
// one item per cycle unless out_stall; items pass the input then the result register
// the whole calendar carry ripple is combinational inside rtc_core
// an item waits in the input register while the result register is stalled
// synchronous active-low reset: calendar 2000-01-01 00:00:00, tick rate 1000 per second
module rtc_calendar_tick (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [11:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  input  logic [31:0] in_set_epoch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [9:0]  out_millis,
  output logic [31:0] out_uptime,
  output logic [31:0] out_epoch
);

  logic [1:0]          rate_sel_r;
  logic                s1_valid_r;
  rtc_pkg::rtc_item_t  s1_item_r;
  logic                out_valid_r;
  rtc_pkg::rtc_state_t out_res_r;
  rtc_pkg::rtc_state_t st_nxt;
  logic                s1_go;
  logic                in_acc;

  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  rtc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s1_go),
    .item     (s1_item_r),
    .rate_sel (rate_sel_r),
    .st_nxt   (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_sel_r  <= rtc_pkg::RATE_1KHZ;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate_sel_r <= cfg_wr_data;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.mode       <= in_mode;
      s1_item_r.set_year   <= in_set_year;
      s1_item_r.set_month  <= in_set_month;
      s1_item_r.set_day    <= in_set_day;
      s1_item_r.set_hour   <= in_set_hour;
      s1_item_r.set_minute <= in_set_minute;
      s1_item_r.set_second <= in_set_second;
      s1_item_r.set_epoch  <= in_set_epoch;
    end
    if (s1_go) begin
      out_res_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_year   = out_res_r.year;
  assign out_month  = out_res_r.month;
  assign out_day    = out_res_r.day;
  assign out_hour   = out_res_r.hour;
  assign out_minute = out_res_r.minute;
  assign out_second = out_res_r.second;
  assign out_millis = out_res_r.millis;
  assign out_uptime = out_res_r.uptime;
  assign out_epoch  = out_res_r.epoch;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room downstream");

  a_millis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.millis < 10'd1000)
    else $error("millisecond field out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");
`endif

endmodule
